[rtl/cdq_pkg.sv]
// shared types and constants for the circular array deque
`default_nettype none

package cdq_pkg;

    // number of element cells in the chain
    localparam int unsigned DEPTH = 16;

    // element width
    localparam int unsigned DATA_W = 32;

    typedef logic [DATA_W-1:0] data_t;

    // request codes
    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_REAR  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_REAR   = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // command broadcast to every cell in the same cycle
    typedef struct packed {
        logic  shift_right;
        logic  shift_left;
        logic  load_rear;
        logic  drop_rear;
        data_t value;
    } cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/circular_array_deque_core.sv]
// Double-ended queue of up to DEPTH signed 32-bit elements held in a chain of cells.
// The front element always sits in the first cell and the occupied cells form one
// unbroken run; pushes and pops at the front shift the whole chain by one cell,
// while rear operations touch only the cell at the end of the run. A request is
// taken on any cycle with start high (busy never rises), so one request per clock
// is sustained; each request gives exactly one result, shown with done high on the
// cycle right after acceptance, and the receiver has no way to hold it off. The
// cell update is a registered step of the chain.
// now_empty and now_full reflect the state after the request being reported.
`default_nettype none

module circular_array_deque_core
    import cdq_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic        [1:0]  opcode,
    input  wire logic signed [31:0] push_value,
    output logic                    done,
    output logic signed      [31:0] pop_value,
    output logic             [1:0]  status,
    output logic                    now_empty,
    output logic                    now_full
);

    data_t             cell_data [DEPTH];
    data_t             cell_tap  [DEPTH];
    logic  [DEPTH-1:0] valid_vec;
    cell_ctrl_t        ctrl;

    logic    accept;
    op_t     op;
    logic    is_push;
    logic    deque_empty;
    logic    deque_full;
    logic    refused;
    data_t   rear_value;

    logic    done_reg;
    logic    done_next;
    data_t   pop_value_reg;
    data_t   pop_value_next;
    status_t status_reg;
    status_t status_next;

    // request decode
    assign busy        = 1'b0;
    assign accept      = start && !busy;
    assign op          = op_t'(opcode);
    assign is_push     = (op == OP_PUSH_FRONT) || (op == OP_PUSH_REAR);
    assign deque_empty = !valid_vec[0];
    assign deque_full  = valid_vec[DEPTH-1];
    assign refused     = is_push ? deque_full : deque_empty;

    // command to the chain
    always_comb
    begin
        ctrl             = '0;
        ctrl.value       = data_t'(push_value);
        if (accept && !refused)
        begin
            case (op)
                OP_PUSH_FRONT: ctrl.shift_right = 1'b1;
                OP_PUSH_REAR:  ctrl.load_rear   = 1'b1;
                OP_POP_FRONT:  ctrl.shift_left  = 1'b1;
                OP_POP_REAR:   ctrl.drop_rear   = 1'b1;
                default:       ctrl             = '0;
            endcase
        end
    end

    // the chain of cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        data_t left_d;
        logic  left_v;
        data_t right_d;
        logic  right_v;

        if (i == 0)
        begin : g_head
            assign left_d = data_t'(push_value);
            assign left_v = 1'b1;
        end
        else
        begin : g_link_left
            assign left_d = cell_data[i-1];
            assign left_v = valid_vec[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_d = '0;
            assign right_v = 1'b0;
        end
        else
        begin : g_link_right
            assign right_d = cell_data[i+1];
            assign right_v = valid_vec[i+1];
        end

        cdq_cell u_cell
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .left_data   (left_d),
            .left_valid  (left_v),
            .right_data  (right_d),
            .right_valid (right_v),
            .data        (cell_data[i]),
            .valid       (valid_vec[i]),
            .rear_tap    (cell_tap[i])
        );
    end

    // rear element: only the last occupied cell drives its value onto its tap, all others drive zero
    always_comb
    begin
        rear_value = '0;
        for (int unsigned i = 0; i < DEPTH; i++)
        begin
            rear_value = rear_value | cell_tap[i];
        end
    end

    // result for the request taken this cycle
    always_comb
    begin
        done_next      = accept;
        pop_value_next = '0;
        status_next    = ST_OK;
        if (refused)
        begin
            status_next = is_push ? ST_FULL : ST_EMPTY;
        end
        else if (op == OP_POP_FRONT)
        begin
            pop_value_next = cell_data[0];
        end
        else if (op == OP_POP_REAR)
        begin
            pop_value_next = rear_value;
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        pop_value_reg <= pop_value_next;
        status_reg    <= status_next;
    end

    assign done      = done_reg;
    assign pop_value = signed'(pop_value_reg);
    assign status    = status_reg;
    assign now_empty = deque_empty;
    assign now_full  = deque_full;

    // occupied cells always form one run starting at the front
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_vec[DEPTH-1:1] & ~valid_vec[DEPTH-2:0]) == '0)
        else $error("deque cells not contiguous");

    // every request is answered on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("missing result strobe");

    // a refused request leaves the chain untouched
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && refused) |=> $stable(valid_vec))
        else $error("refused request changed the deque");

    // without a request the chain holds
    assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(valid_vec))
        else $error("deque changed without a request");

    // an empty refusal reports an empty deque
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_EMPTY)) |-> (now_empty && pop_value == '0))
        else $error("empty refusal with inconsistent result");

endmodule

`default_nettype wire

[rtl/cdq_cell.sv]
// one element cell of the deque chain: holds a value and its occupied flag
`default_nettype none

module cdq_cell
    import cdq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctrl_t ctrl,
    input  wire data_t      left_data,
    input  wire logic       left_valid,
    input  wire data_t      right_data,
    input  wire logic       right_valid,
    output data_t           data,
    output logic            valid,
    output data_t           rear_tap
);

    data_t data_reg;
    data_t data_next;
    logic  valid_reg;
    logic  valid_next;

    // next value from the broadcast command and the two neighbors
    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (ctrl.shift_right)
        begin
            data_next  = left_data;
            valid_next = left_valid;
        end
        else if (ctrl.shift_left)
        begin
            data_next  = right_data;
            valid_next = right_valid;
        end
        else if (ctrl.load_rear)
        begin
            // first free cell after the occupied run takes the new element
            if (!valid_reg && left_valid)
            begin
                data_next  = ctrl.value;
                valid_next = 1'b1;
            end
        end
        else if (ctrl.drop_rear)
        begin
            // last occupied cell lets go of its element
            if (valid_reg && !right_valid)
            begin
                valid_next = 1'b0;
            end
        end
    end

    // occupied flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // element value, meaningful only while occupied
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    assign valid    = valid_reg;
    assign rear_tap = (valid_reg && !right_valid) ? data_reg : '0;

endmodule

`default_nettype wire
